>>> sv/fat12_cluster_chain_walker_macros.svh
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker assertion macros
// Concurrent assertion helpers; the bodies compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge out of reset.
`define FAT12_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fat12 assertion failed");

// Consequent must hold on the clock edge after the antecedent.
`define FAT12_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fat12 assertion failed");

`else

`define FAT12_ASSERT(lbl, clk, rstn, prop)
`define FAT12_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> sv/fat12_pkg.sv
// ----------------------------------------------------------------------------
// FAT12 walker package
// Shared constants, request and status codes, and the table write bundle.
// ----------------------------------------------------------------------------
package fat12_pkg;

  localparam int unsigned FAT_ENTRIES_DEF = 3072;
  // Sector size is a power of two; sector counts come from a shift.
  localparam int unsigned SECTOR_BYTES    = 512;
  localparam int unsigned SECTOR_SHIFT    = $clog2(SECTOR_BYTES);

  localparam int unsigned ENTRY_W   = 12;
  localparam int unsigned SECTOR_W  = 16;
  localparam int unsigned LEFT_W    = 24;
  localparam int unsigned SIZE_W    = 32;

  localparam logic [SECTOR_W-1:0] DATA_START_RST = 16'd33;
  localparam logic [ENTRY_W-1:0]  END_MARK       = 12'hFF8;
  localparam logic [ENTRY_W-1:0]  ENTRY_BEYOND   = 12'hFFF;
  localparam logic [ENTRY_W-1:0]  FIRST_DATA_CL  = 12'd2;
  localparam logic [7:0]          NIBBLE_MASK    = 8'h0F;
  localparam logic [LEFT_W-1:0]   LEFT_MAX       = {LEFT_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_OPEN = 2'd1,
    REQ_NEXT = 2'd2,
    REQ_RSVD = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STAT_SECTOR    = 3'd0,
    STAT_LOAD_OK   = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_UNRECOV   = 3'd3,
    STAT_CHAIN_END = 3'd4,
    STAT_NO_OPEN   = 3'd5
  } status_e;

  // Write of one unpacked byte triple: even and odd table banks.
  typedef struct packed {
    logic               we_even;
    logic               we_odd;
    logic [ENTRY_W-1:0] data_even;
    logic [ENTRY_W-1:0] data_odd;
  } fat12_wr_t;

endpackage

>>> sv/fat12_ram.sv
// ----------------------------------------------------------------------------
// FAT12 generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fat12_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/fat12_loader.sv
// ----------------------------------------------------------------------------
// FAT12 table loader
// Collects FAT bytes in threes and writes two 12-bit entries per triple.
// ----------------------------------------------------------------------------
module fat12_loader
  import fat12_pkg::*;
#(
  parameter int unsigned FAT_ENTRIES = FAT_ENTRIES_DEF,
  localparam int unsigned BANK_DEPTH = (FAT_ENTRIES + 1) / 2,
  localparam int unsigned ODD_DEPTH  = FAT_ENTRIES / 2,
  localparam int unsigned ADDR_W     = $clog2(BANK_DEPTH),
  localparam int unsigned TRIPLE_W   = $clog2(BANK_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [7:0]        byte_i,
  output fat12_wr_t         wr_o,
  output logic [ADDR_W-1:0] waddr_o
);

  logic [1:0]          phase_q, phase_d;
  logic [TRIPLE_W-1:0] triple_q, triple_d;
  logic [7:0]          first_q, first_d;
  logic [7:0]          second_q, second_d;
  logic [7:0]          second_lo;
  logic                room;

  // Bytes past the last triple are answered but dropped.
  assign room = triple_q < TRIPLE_W'(BANK_DEPTH);

  assign second_lo = second_q & NIBBLE_MASK;

  always_comb begin
    phase_d  = phase_q;
    triple_d = triple_q;
    first_d  = first_q;
    second_d = second_q;
    if (load_i && room) begin
      case (phase_q)
        2'd0: begin
          first_d = byte_i;
          phase_d = 2'd1;
        end
        2'd1: begin
          second_d = byte_i;
          phase_d  = 2'd2;
        end
        default: begin
          phase_d  = 2'd0;
          triple_d = triple_q + TRIPLE_W'(1);
        end
      endcase
    end
  end

  always_comb begin
    wr_o.we_even   = load_i && room && (phase_q == 2'd2);
    // Odd entry of the last triple may lie beyond the table.
    wr_o.we_odd    = wr_o.we_even && (triple_q < TRIPLE_W'(ODD_DEPTH));
    wr_o.data_even = {second_lo[3:0], first_q};
    wr_o.data_odd  = {byte_i, second_q[7:4]};
  end

  assign waddr_o = triple_q[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 2'd0;
      triple_q <= '0;
      first_q  <= '0;
      second_q <= '0;
    end else begin
      phase_q  <= phase_d;
      triple_q <= triple_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

>>> sv/fat12_cluster_chain_walker.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker
// Loads a FAT12 table from raw bytes and walks a file's cluster chain,
// giving one data sector per next request.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake          Payload
//  s_axis    in   tvalid/tready      tuser: request kind; tdata: byte, open
//  m_axis    out  tvalid/tready      tdata: sector; tuser: status; tlast
//  apb       in   psel/penable       data_start_sector at byte address 0
//
//  Load, reserved and no-walk next items, a chain end, an empty open, a contiguous
//  next and the last sector of a chain finish in the idle state. Any other open and
//  chained next also pass a check or read state that waits on the registered table read.
//  Reset clears the walk and the load count; the table stays undefined until loaded.
//  A stalled output holds the block: a new item is taken only when the output
//  register is empty or being taken in the same cycle.
// ----------------------------------------------------------------------------
`include "fat12_cluster_chain_walker_macros.svh"

module fat12_cluster_chain_walker
  import fat12_pkg::*;
#(
  parameter int unsigned FAT_ENTRIES = FAT_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata_i: [7:0] fat_byte, [19:8] start_cluster, [51:20] file length,
  //                 [52] is_deleted, [55:53] zero
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,
  // s_axis_tuser_i: [1:0] req_type
  input  logic [1:0]  s_axis_tuser_i,
  // m_axis_tdata_o: [15:0] data sector
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,
  // m_axis_tuser_o: [2:0] status
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned BANK_DEPTH = (FAT_ENTRIES + 1) / 2;
  localparam int unsigned ADDR_W     = $clog2(BANK_DEPTH);
  localparam logic        CFG_WORD_DSS = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OPEN_CHK,
    ST_NEXT_RD
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [SECTOR_W-1:0] dss_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dss_q <= DATA_START_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_WORD_DSS)) begin
      dss_q <= pwdata[SECTOR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_WORD_DSS) ? {16'd0, dss_q} : 32'd0;

  // --------------------------------------------------------------------------
  // Input unpack
  // --------------------------------------------------------------------------
  req_e               req;
  logic [7:0]         in_byte;
  logic [ENTRY_W-1:0] in_start;
  logic [SIZE_W-1:0]  in_size;
  logic               in_del;
  logic               in_acc;

  assign req      = req_e'(s_axis_tuser_i);
  assign in_byte  = s_axis_tdata_i[7:0];
  assign in_start = s_axis_tdata_i[19:8];
  assign in_size  = s_axis_tdata_i[51:20];
  assign in_del   = s_axis_tdata_i[52];

  state_e              state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic [SECTOR_W-1:0] out_sector_q, out_sector_d;
  status_e             out_status_q, out_status_d;
  logic                out_last_q, out_last_d;

  // Take an item only when idle and the output register can take a result.
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // --------------------------------------------------------------------------
  // Table memory: even and odd entries in two banks, so one byte triple
  // writes both of its entries in the same cycle. Writes come only from load
  // items and reads only from open and next items, one item at a time, so
  // no access to the same entry ever overlaps.
  // --------------------------------------------------------------------------
  fat12_wr_t           wr;
  logic [ADDR_W-1:0]   waddr;
  logic                ld_acc;

  assign ld_acc = in_acc && (req == REQ_LOAD);

  fat12_loader #(
    .FAT_ENTRIES(FAT_ENTRIES)
  ) u_loader (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (ld_acc),
    .byte_i (in_byte),
    .wr_o   (wr),
    .waddr_o(waddr)
  );

  logic [ENTRY_W-1:0] cur_cluster_q, cur_cluster_d;
  logic [ENTRY_W-1:0] rd_cluster;
  logic               rd_in_range;
  logic               ram_re;
  logic [ADDR_W-1:0]  raddr;
  logic               rd_bank_q;
  logic               rd_beyond_q;
  logic [ENTRY_W-1:0] even_rdata;
  logic [ENTRY_W-1:0] odd_rdata;
  logic [ENTRY_W-1:0] entry;

  assign rd_cluster  = (req == REQ_OPEN) ? in_start : cur_cluster_q;
  assign rd_in_range = {1'b0, rd_cluster} < (ENTRY_W + 1)'(FAT_ENTRIES);
  assign ram_re      = in_acc && rd_in_range && ((req == REQ_OPEN) || (req == REQ_NEXT));
  assign raddr       = rd_cluster[ADDR_W:1];

  fat12_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(BANK_DEPTH)
  ) u_ram_even (
    .clk_i  (clk_i),
    .we_i   (wr.we_even),
    .waddr_i(waddr),
    .wdata_i(wr.data_even),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(even_rdata)
  );

  fat12_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(BANK_DEPTH)
  ) u_ram_odd (
    .clk_i  (clk_i),
    .we_i   (wr.we_odd),
    .waddr_i(waddr),
    .wdata_i(wr.data_odd),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(odd_rdata)
  );

  // Entries beyond the table read as end of chain.
  assign entry = rd_beyond_q ? ENTRY_BEYOND : (rd_bank_q ? odd_rdata : even_rdata);

  // --------------------------------------------------------------------------
  // Walk control
  // --------------------------------------------------------------------------
  logic [SECTOR_W-1:0] cur_sector_q, cur_sector_d;
  logic [LEFT_W-1:0]   left_q, left_d;
  logic                active_q, active_d;
  logic                contig_q, contig_d;
  logic [ENTRY_W-1:0]  open_start_q, open_start_d;
  logic                open_del_q, open_del_d;
  logic [LEFT_W-1:0]   open_secs_q, open_secs_d;

  logic [SIZE_W:0]     size_round;
  logic [SIZE_W:0]     secs_full;
  logic [LEFT_W-1:0]   secs_sat;
  logic [SECTOR_W-1:0] chain_sector;
  logic [SECTOR_W-1:0] start_sector;
  logic [SECTOR_W-1:0] next_sector;
  logic                chain_end;

  function automatic logic [SECTOR_W-1:0] sector_of(input logic [SECTOR_W-1:0] dss,
                                                    input logic [ENTRY_W-1:0]  cl);
    sector_of = dss + {{(SECTOR_W - ENTRY_W){1'b0}}, cl}
                    - {{(SECTOR_W - ENTRY_W){1'b0}}, FIRST_DATA_CL};
  endfunction

  // Round the byte count up to whole sectors, saturate to the counter.
  assign size_round = {1'b0, in_size} + (SIZE_W + 1)'(SECTOR_BYTES - 1);
  assign secs_full  = size_round >> SECTOR_SHIFT;
  assign secs_sat   = (secs_full > (SIZE_W + 1)'(LEFT_MAX)) ? LEFT_MAX
                                                            : secs_full[LEFT_W-1:0];

  assign chain_sector = sector_of(dss_q, cur_cluster_q);
  assign start_sector = sector_of(dss_q, open_start_q);
  assign next_sector  = contig_q ? cur_sector_q : chain_sector;
  assign chain_end    = !contig_q && ((cur_cluster_q < FIRST_DATA_CL) ||
                                      (cur_cluster_q >= END_MARK));

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_sector_d  = out_sector_q;
    out_status_d  = out_status_q;
    out_last_d    = out_last_q;
    cur_cluster_d = cur_cluster_q;
    cur_sector_d  = cur_sector_q;
    left_d        = left_q;
    active_d      = active_q;
    contig_d      = contig_q;
    open_start_d  = open_start_q;
    open_del_d    = open_del_q;
    open_secs_d   = open_secs_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (req)
            REQ_LOAD: begin
              out_valid_d  = 1'b1;
              out_sector_d = '0;
              out_status_d = STAT_LOAD_OK;
              out_last_d   = 1'b0;
            end
            REQ_OPEN: begin
              // Any open drops the walk in progress.
              active_d = 1'b0;
              if (in_size == '0) begin
                out_valid_d  = 1'b1;
                out_sector_d = '0;
                out_status_d = STAT_EMPTY;
                out_last_d   = 1'b1;
              end else begin
                open_start_d = in_start;
                open_del_d   = in_del;
                open_secs_d  = secs_sat;
                state_d      = ST_OPEN_CHK;
              end
            end
            REQ_NEXT: begin
              if (!active_q) begin
                out_valid_d  = 1'b1;
                out_sector_d = '0;
                out_status_d = STAT_NO_OPEN;
                out_last_d   = 1'b0;
              end else if (chain_end) begin
                active_d     = 1'b0;
                out_valid_d  = 1'b1;
                out_sector_d = '0;
                out_status_d = STAT_CHAIN_END;
                out_last_d   = 1'b1;
              end else begin
                left_d       = left_q - LEFT_W'(1);
                out_valid_d  = 1'b1;
                out_sector_d = next_sector;
                out_status_d = STAT_SECTOR;
                if (left_q == LEFT_W'(1)) begin
                  active_d   = 1'b0;
                  out_last_d = 1'b1;
                end else begin
                  out_last_d = 1'b0;
                  if (contig_q) begin
                    cur_sector_d = cur_sector_q + SECTOR_W'(1);
                  end else begin
                    // Follow the chain once the entry comes back.
                    state_d = ST_NEXT_RD;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_OPEN_CHK: begin
        state_d = ST_IDLE;
        if (open_del_q && (entry != '0)) begin
          out_valid_d  = 1'b1;
          out_sector_d = '0;
          out_status_d = STAT_UNRECOV;
          out_last_d   = 1'b1;
        end else begin
          left_d        = open_secs_q;
          cur_cluster_d = open_start_q;
          cur_sector_d  = start_sector;
          contig_d      = open_del_q;
          active_d      = 1'b1;
        end
      end
      ST_NEXT_RD: begin
        state_d       = ST_IDLE;
        cur_cluster_d = entry;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      out_sector_q  <= '0;
      out_status_q  <= STAT_SECTOR;
      out_last_q    <= 1'b0;
      cur_cluster_q <= '0;
      cur_sector_q  <= '0;
      left_q        <= '0;
      active_q      <= 1'b0;
      contig_q      <= 1'b0;
      open_start_q  <= '0;
      open_del_q    <= 1'b0;
      open_secs_q   <= '0;
      rd_bank_q     <= 1'b0;
      rd_beyond_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      out_sector_q  <= out_sector_d;
      out_status_q  <= out_status_d;
      out_last_q    <= out_last_d;
      cur_cluster_q <= cur_cluster_d;
      cur_sector_q  <= cur_sector_d;
      left_q        <= left_d;
      active_q      <= active_d;
      contig_q      <= contig_d;
      open_start_q  <= open_start_d;
      open_del_q    <= open_del_d;
      open_secs_q   <= open_secs_d;
      if (in_acc) begin
        rd_bank_q   <= rd_cluster[0];
        rd_beyond_q <= !rd_in_range;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_sector_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FAT12_ASSERT(a_no_rw_overlap, clk_i, rst_ni, !(ram_re && (wr.we_even || wr.we_odd)))
  `FAT12_ASSERT(a_next_rd_in_walk, clk_i, rst_ni, (state_q != ST_NEXT_RD) || active_q)
  `FAT12_ASSERT_NEXT(a_next_no_walk, clk_i, rst_ni, in_acc && (req == REQ_NEXT) && !active_q, m_axis_tvalid_o && (m_axis_tuser_o == STAT_NO_OPEN))
  `FAT12_ASSERT(a_end_status_last, clk_i, rst_ni, !m_axis_tvalid_o || !((m_axis_tuser_o == STAT_EMPTY) || (m_axis_tuser_o == STAT_UNRECOV) || (m_axis_tuser_o == STAT_CHAIN_END)) || m_axis_tlast_o)

endmodule
